// File: rtl/bda_pkg.sv
// Shared constants, types and helpers for the binary to decimal ASCII converter.
// No dependencies.
package bda_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int DIGIT_W        = 4;
  localparam int CHAR_W         = 6;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
  localparam logic [CHAR_W-1:0] ASCII_NINE = 6'd57;

  // decimal digits of 2**bits - 1; 1233/4096 is just under log10(2)
  function automatic int dec_digits(input int bits);
    return ((bits * 1233) >> 12) + 1;
  endfunction

  typedef struct packed {
    logic valid;
    logic is_zero;
  } q_ctl_t;

endpackage

// File: rtl/bda_intf.sv
// Valid/ready channel interfaces for the converter's input and result words.
// Depends on bda_pkg.
interface bda_in_if import bda_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
  modport mon    (input valid, input value, input ready);
endinterface

interface bda_out_if import bda_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] digit_char;
  logic              last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);
  modport mon    (input valid, input digit_char, input last_digit, input ready);
endinterface

// File: rtl/bda_front.sv
// Front end: accepts input words, flags zero values, holds them in a small queue.
// Depends on bda_pkg and bda_in_if.
module bda_front import bda_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bda_in_if.sink                in_chan,
  output logic [VALUE_BITS-1:0] q_value,
  output q_ctl_t                q_ctl,
  input  logic                  q_pop
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [VALUE_BITS-1:0] val_r  [QUEUE_DEPTH];
  logic                  zero_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  push, pop;

  assign in_chan.ready = (cnt_r != CNT_W'(QUEUE_DEPTH));
  assign push          = in_chan.valid && in_chan.ready;
  assign pop           = q_pop && q_ctl.valid;

  assign q_value       = val_r[rd_ptr_r];
  assign q_ctl.valid   = (cnt_r != '0);
  assign q_ctl.is_zero = zero_r[rd_ptr_r];

  // depth is a power of two, pointers wrap naturally
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      val_r[wr_ptr_r]  <= in_chan.value;
      zero_r[wr_ptr_r] <= (in_chan.value == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// File: rtl/bda_back.sv
// Back end: shift-and-add-3 conversion, then digit emission with leading-zero skip.
// Depends on bda_pkg and bda_out_if.
module bda_back import bda_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [VALUE_BITS-1:0] q_value,
  input  q_ctl_t                q_ctl,
  output logic                  q_pop,
  bda_out_if.source             out_chan
);

  localparam int NDIG  = dec_digits(VALUE_BITS);
  localparam int BCD_W = NDIG * DIGIT_W;
  localparam int CNT_W = $clog2(VALUE_BITS);
  localparam int REM_W = $clog2(NDIG + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  logic [VALUE_BITS-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0]      bcd_r, bcd_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [REM_W-1:0]      rem_r, rem_nxt;
  logic                  lead_r, lead_nxt;
  logic                  ov_r, ov_nxt;
  logic [CHAR_W-1:0]     oc_r, oc_nxt;
  logic                  ol_r, ol_nxt;
  logic [BCD_W-1:0]      adj;
  logic [DIGIT_W-1:0]    top_dig;
  logic                  show;
  logic                  slot;

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[i*DIGIT_W +: DIGIT_W] = (bcd_r[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) ?
                                  bcd_r[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3) :
                                  bcd_r[i*DIGIT_W +: DIGIT_W];
    end
  end

  assign top_dig = bcd_r[BCD_W-1 -: DIGIT_W];
  assign show    = lead_r || (top_dig != '0) || (rem_r == REM_W'(1));
  assign slot    = !ov_r || out_chan.ready;

  always_comb begin
    state_nxt = state_r;
    bin_nxt   = bin_r;
    bcd_nxt   = bcd_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    lead_nxt  = lead_r;
    ov_nxt    = ov_r && !out_chan.ready;
    oc_nxt    = oc_r;
    ol_nxt    = ol_r;
    q_pop     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_ctl.valid) begin
          q_pop    = 1'b1;
          bin_nxt  = q_value;
          bcd_nxt  = '0;
          lead_nxt = 1'b0;
          if (q_ctl.is_zero) begin
            rem_nxt   = REM_W'(1);
            state_nxt = ST_EMIT;
          end else begin
            cnt_nxt   = CNT_W'(VALUE_BITS - 1);
            rem_nxt   = REM_W'(NDIG);
            state_nxt = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        bcd_nxt = {adj[BCD_W-2:0], bin_r[VALUE_BITS-1]};
        bin_nxt = {bin_r[VALUE_BITS-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!show || slot) begin
          bcd_nxt = {bcd_r[BCD_W-DIGIT_W-1:0], DIGIT_W'(0)};
          rem_nxt = rem_r - 1'b1;
          if (show) begin
            ov_nxt   = 1'b1;
            oc_nxt   = ASCII_ZERO + CHAR_W'(top_dig);
            ol_nxt   = (rem_r == REM_W'(1));
            lead_nxt = 1'b1;
            if (rem_r == REM_W'(1)) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    oc_r  <= oc_nxt;
    ol_r  <= ol_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      lead_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      lead_r  <= lead_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign out_chan.valid      = ov_r;
  assign out_chan.digit_char = oc_r;
  assign out_chan.last_digit = ol_r;

endmodule

// File: rtl/binary_to_decimal_ascii.sv
// Top level of the binary to decimal ASCII converter.
// Depends on bda_pkg, bda_intf, bda_front and bda_back.
//
// in_chan carries one unsigned VALUE_BITS-wide number per word. out_chan carries
// one ASCII digit per word, most significant first, last_digit set on the final
// digit of a number. Leading zeros are dropped; zero gives the single word '0'.
// Both channels handshake on valid && ready.
// Accepted numbers wait in a two-word queue, so the sender can run ahead of the
// converter. The converter works on one number at a time (NDIG = 10 digit slots
// at 32 bits): one shift-and-add-3 step per cycle, then one digit slot per
// cycle while the receiver takes digits (skipped leading zeros never wait).
// A zero value skips the conversion. The first digit follows the conversion,
// later when leading zeros are skipped or the converter is still busy.
// A stalled receiver holds the current digit in the output register and the
// converter waits; the queue keeps accepting until full.
// Synchronous reset empties the queue and the output register; no clearing pass.
module binary_to_decimal_ascii import bda_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bda_in_if.sink    in_chan,
  bda_out_if.source out_chan
);

  logic [VALUE_BITS-1:0] q_value;
  q_ctl_t                q_ctl;
  logic                  q_pop;

  bda_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_value (q_value),
    .q_ctl   (q_ctl),
    .q_pop   (q_pop)
  );

  bda_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_value  (q_value),
    .q_ctl    (q_ctl),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule

// File: rtl/bda_chk.sv
// Port-level checker for the converter, bound to the top level.
// Depends on bda_pkg; watches the top level's channel signals.
module bda_chk import bda_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAR_W-1:0] out_digit_char,
  input logic              out_last_digit
);

  localparam int NDIG  = dec_digits(VALUE_BITS);
  localparam int RUN_W = $clog2(NDIG + 1);

  logic             in_acc, out_acc;
  logic [3:0]       pend_r, pend_nxt;
  logic [RUN_W-1:0] run_r, run_nxt;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    pend_nxt = pend_r + {3'b0, in_acc} - {3'b0, out_acc && out_last_digit};
    run_nxt  = run_r;
    if (out_acc) begin
      run_nxt = out_last_digit ? '0 : run_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      run_r  <= '0;
    end else begin
      pend_r <= pend_nxt;
      run_r  <= run_nxt;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable(out_digit_char) && $stable(out_last_digit))
    else $error("result word changed while stalled");

  a_ascii: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> out_digit_char >= ASCII_ZERO && out_digit_char <= ASCII_NINE)
    else $error("digit outside '0'..'9'");

  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> pend_r != '0)
    else $error("digit sent with no number outstanding");

  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && run_r == RUN_W'(NDIG - 1) |-> out_last_digit)
    else $error("run longer than the digit count allows");

  a_lead: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && run_r == '0 && !out_last_digit |-> out_digit_char != ASCII_ZERO)
    else $error("leading zero sent");

endmodule

bind binary_to_decimal_ascii bda_chk #(
  .VALUE_BITS (VALUE_BITS)
) u_bda_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_digit_char (out_chan.digit_char),
  .out_last_digit (out_chan.last_digit)
);
